// ===== rtl/svng_pkg.sv =====
// Shared types and constants for the smooth vertex normal generator.
// No dependencies; imported by every module of the block.
package svng_pkg;

  // Request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_TRI   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam int IDX_W   = 12;
  localparam int COUNT_W = 13;
  localparam int POS_W   = 32;
  localparam int ACC_W   = 32;
  localparam int NRM_W   = 16;
  localparam int VEC_W   = 64;

  // Classified request as it travels from front to back
  typedef struct packed {
    logic [1:0]              op;
    logic                    err;
    logic [IDX_W-1:0]        vidx;
    logic [IDX_W-1:0]        ca;
    logic [IDX_W-1:0]        cb;
    logic [IDX_W-1:0]        cc;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
  } item_t;

endpackage

// ===== rtl/svng_norm.sv =====
// Iterative unit-length scaler: 3 x 64-bit signed vector to 3 x Q1.15.
// Depends on svng_pkg. Shift, square-sum, bit-pair sqrt and restoring divide.
module svng_norm import svng_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [VEC_W-1:0]        vx,
  input  logic [VEC_W-1:0]        vy,
  input  logic [VEC_W-1:0]        vz,
  output logic                    done,
  output logic signed [NRM_W-1:0] nx,
  output logic signed [NRM_W-1:0] ny,
  output logic signed [NRM_W-1:0] nz
);

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DSET  = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;

  logic [2:0]  state;
  logic [63:0] m0, m1, m2;
  logic [2:0]  neg;
  logic [59:0] sq;
  logic [61:0] len2;
  logic [1:0]  k;
  logic [61:0] r;
  logic [61:0] bitv;
  logic [30:0] len;
  logic [1:0]  comp;
  logic [15:0] num_lo;
  logic [31:0] rem;
  logic [15:0] q;
  logic [3:0]  step;

  logic [63:0] mx;
  logic [29:0] msel;
  logic [29:0] mdiv;
  logic [61:0] sqrt_t;
  logic [45:0] num;
  logic [31:0] rem2;
  logic        qbit;
  logic [15:0] q_fin;
  logic [15:0] n_fin;

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [15:0] clamp(input logic [15:0] qq, input logic ng);
    if (ng) begin
      return (qq > 16'd32768) ? 16'h8000 : (16'd0 - qq);
    end else begin
      return (qq > 16'd32767) ? 16'h7FFF : qq;
    end
  endfunction

  // Largest magnitude
  always_comb begin
    mx = m0;
    if (m1 > mx) mx = m1;
    if (m2 > mx) mx = m2;
  end

  // Operand selects
  always_comb begin
    case (k)
      2'd0:    msel = m0[29:0];
      2'd1:    msel = m1[29:0];
      2'd2:    msel = m2[29:0];
      default: msel = m0[29:0];
    endcase
    case (comp)
      2'd0:    mdiv = m0[29:0];
      2'd1:    mdiv = m1[29:0];
      2'd2:    mdiv = m2[29:0];
      default: mdiv = m0[29:0];
    endcase
  end

  // Sqrt and divide step logic
  assign sqrt_t = r + bitv;
  assign num    = {1'b0, mdiv, 15'd0} + {16'd0, len[30:1]};
  assign rem2   = {rem[30:0], num_lo[15]};
  assign qbit   = (rem2 >= {1'b0, len});
  assign q_fin  = {q[14:0], qbit};
  assign n_fin  = clamp(q_fin, neg[comp]);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        N_IDLE: begin
          if (start) state <= N_SHIFT;
        end
        N_SHIFT: begin
          if (mx == 64'd0) begin
            done  <= 1'b1;
            state <= N_IDLE;
          end else if ((|mx[63:30]) == 1'b0 && mx[29]) begin
            state <= N_SQ;
          end
        end
        N_SQ: begin
          if (k == 2'd3) state <= N_SQRT;
        end
        N_SQRT: begin
          if (bitv == 62'd0) state <= N_DSET;
        end
        N_DSET: state <= N_DIV;
        N_DIV: begin
          if (step == 4'd0) begin
            if (comp == 2'd2) begin
              done  <= 1'b1;
              state <= N_IDLE;
            end else begin
              state <= N_DSET;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      N_IDLE: begin
        if (start) begin
          m0  <= mag(vx);
          m1  <= mag(vy);
          m2  <= mag(vz);
          neg <= {vz[63], vy[63], vx[63]};
        end
      end
      N_SHIFT: begin
        k    <= 2'd0;
        len2 <= 62'd0;
        if (mx == 64'd0) begin
          nx <= '0;
          ny <= '0;
          nz <= '0;
        end else if (|mx[63:30]) begin
          m0 <= m0 >> 1;
          m1 <= m1 >> 1;
          m2 <= m2 >> 1;
        end else if (!mx[29]) begin
          m0 <= m0 << 1;
          m1 <= m1 << 1;
          m2 <= m2 << 1;
        end
      end
      N_SQ: begin
        // one square per cycle, summed into len2 in the next cycle
        if (k != 2'd3) sq <= msel * msel;
        if (k != 2'd0) len2 <= len2 + {2'd0, sq};
        k    <= k + 2'd1;
        r    <= 62'd0;
        bitv <= 62'd1 << 60;
      end
      N_SQRT: begin
        if (bitv == 62'd0) begin
          len  <= r[30:0];
          comp <= 2'd0;
        end else begin
          if (len2 >= sqrt_t) begin
            len2 <= len2 - sqrt_t;
            r    <= (r >> 1) + bitv;
          end else begin
            r <= r >> 1;
          end
          bitv <= bitv >> 2;
        end
      end
      N_DSET: begin
        rem    <= {2'd0, num[45:16]};
        num_lo <= num[15:0];
        step   <= 4'd15;
      end
      N_DIV: begin
        rem    <= qbit ? (rem2 - {1'b0, len}) : rem2;
        num_lo <= num_lo << 1;
        q      <= q_fin;
        step   <= step - 4'd1;
        if (step == 4'd0) begin
          case (comp)
            2'd0:    nx <= n_fin;
            2'd1:    ny <= n_fin;
            default: nz <= n_fin;
          endcase
          comp <= comp + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/svng_front.sv =====
// Front end: index checks against vertex_count and a two-entry request queue.
// Depends on svng_pkg.
module svng_front import svng_pkg::*; #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic                    hold,
  input  logic [1:0]              req_type,
  input  logic [IDX_W-1:0]        vtx_index,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [IDX_W-1:0]        corner_a,
  input  logic [IDX_W-1:0]        corner_b,
  input  logic [IDX_W-1:0]        corner_c,
  input  logic [COUNT_W-1:0]      vertex_count,
  output logic                    q_valid,
  output item_t                   q_item,
  input  logic                    take
);

  localparam logic [16:0] MAXV = 17'(MAX_VERTICES);

  item_t      entry [2];
  item_t      in_item;
  logic       wp, rp;
  logic [1:0] cnt;
  logic       acc;

  function automatic logic idx_ok(input logic [IDX_W-1:0] i, input logic [COUNT_W-1:0] c);
    return ({1'b0, i} < c) && ({5'd0, i} < MAXV);
  endfunction

  // Classify the incoming request
  always_comb begin
    in_item.op   = req_type;
    in_item.vidx = vtx_index;
    in_item.ca   = corner_a;
    in_item.cb   = corner_b;
    in_item.cc   = corner_c;
    in_item.px   = pos_x;
    in_item.py   = pos_y;
    in_item.pz   = pos_z;
    case (req_type)
      REQ_WRITE, REQ_READ: in_item.err = !idx_ok(vtx_index, vertex_count);
      REQ_TRI: in_item.err = !(idx_ok(corner_a, vertex_count) &&
                               idx_ok(corner_b, vertex_count) &&
                               idx_ok(corner_c, vertex_count));
      default: in_item.err = 1'b0;
    endcase
  end

  assign full    = (cnt == 2'd2) || hold;
  assign acc     = push && !full;
  assign q_valid = (cnt != 2'd0);
  assign q_item  = entry[rp];

  // Queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (acc) wp <= ~wp;
      if (take) rp <= ~rp;
      case ({acc, take})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (acc) entry[wp] <= in_item;
  end

endmodule

// ===== rtl/svng_back.sv =====
// Back end: position and accumulator memories, cross product, accumulation,
// clearing sweep and result register. Depends on svng_pkg and svng_norm.
module svng_back import svng_pkg::*; #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  item_t                   in_item,
  output logic                    take,
  output logic                    init_busy,
  input  logic                    pop,
  output logic                    empty,
  output logic signed [NRM_W-1:0] normal_x,
  output logic signed [NRM_W-1:0] normal_y,
  output logic signed [NRM_W-1:0] normal_z,
  output logic                    status
);

  localparam int DEPTH = (MAX_VERTICES < 4096) ? MAX_VERTICES : 4096;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_WRITE  = 4'd2;
  localparam logic [3:0] S_RACC   = 4'd3;
  localparam logic [3:0] S_RSTART = 4'd4;
  localparam logic [3:0] S_PA     = 4'd5;
  localparam logic [3:0] S_PB     = 4'd6;
  localparam logic [3:0] S_PC     = 4'd7;
  localparam logic [3:0] S_EDGE   = 4'd8;
  localparam logic [3:0] S_MUL    = 4'd9;
  localparam logic [3:0] S_FSTART = 4'd10;
  localparam logic [3:0] S_NWAIT  = 4'd11;
  localparam logic [3:0] S_ARD    = 4'd12;
  localparam logic [3:0] S_AWR    = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;

  logic [3:0]  state;
  logic        init;
  item_t       cur;
  logic [AW-1:0] sw;
  logic [95:0] pa, pb;
  logic signed [31:0] e0, e1, e2, e3, e4, e5;
  logic signed [63:0] cr0, cr1, cr2, prod;
  logic [2:0]  mc;
  logic [1:0]  j;
  logic signed [15:0] fnx, fny, fnz;
  logic signed [15:0] rnx, rny, rnz;
  logic        out_valid;

  // Memories
  logic [95:0]   pos_mem [DEPTH];
  logic [95:0]   acc_mem [DEPTH];
  logic [95:0]   pos_rd, acc_rd, acc_wd;
  logic [AW-1:0] pos_ra, acc_ra, acc_wa, corner_addr;
  logic          acc_we;

  // Step logic
  logic signed [32:0] d0, d1, d2, d3, d4, d5;
  logic               wide;
  logic signed [31:0] op1, op2;
  logic [2:0]         kk;
  logic               norm_go, norm_done;
  logic [63:0]        nvx, nvy, nvz;
  logic signed [15:0] nox, noy, noz;
  logic               slot_free;

  function automatic logic signed [32:0] sub33(input logic [31:0] p, input logic [31:0] s);
    return {p[31], p} - {s[31], s};
  endfunction

  function automatic logic signed [31:0] fit(input logic signed [32:0] d, input logic w);
    logic signed [32:0] t;
    t = d + {32'd0, d[32]};
    return w ? t[32:1] : d[31:0];
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [15:0] f);
    logic [32:0] s;
    s = {a[31], a} + {{17{f[15]}}, f};
    if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return s[31:0];
  endfunction

  // Address selects
  always_comb begin
    case (j)
      2'd0:    corner_addr = cur.ca[AW-1:0];
      2'd1:    corner_addr = cur.cb[AW-1:0];
      default: corner_addr = cur.cc[AW-1:0];
    endcase
    case (state)
      S_PB:    pos_ra = cur.cb[AW-1:0];
      S_PC:    pos_ra = cur.cc[AW-1:0];
      default: pos_ra = cur.ca[AW-1:0];
    endcase
    acc_ra = (state == S_ARD) ? corner_addr : cur.vidx[AW-1:0];
    acc_we = (state == S_CLEAR) || (state == S_AWR);
    acc_wa = (state == S_CLEAR) ? sw : corner_addr;
    acc_wd = (state == S_CLEAR) ? 96'd0 :
             {sat_add(acc_rd[95:64], fnx), sat_add(acc_rd[63:32], fny),
              sat_add(acc_rd[31:0], fnz)};
  end

  // Position memory: x, y, z packed high to low
  always_ff @(posedge clk) begin
    if (state == S_WRITE) pos_mem[cur.vidx[AW-1:0]] <= {cur.px, cur.py, cur.pz};
    pos_rd <= pos_mem[pos_ra];
  end

  // Accumulator memory
  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_wa] <= acc_wd;
    acc_rd <= acc_mem[acc_ra];
  end

  // Edge vectors from corners a, b and c
  always_comb begin
    d0 = sub33(pb[95:64], pa[95:64]);
    d1 = sub33(pb[63:32], pa[63:32]);
    d2 = sub33(pb[31:0],  pa[31:0]);
    d3 = sub33(pos_rd[95:64], pa[95:64]);
    d4 = sub33(pos_rd[63:32], pa[63:32]);
    d5 = sub33(pos_rd[31:0],  pa[31:0]);
    wide = (d0[32] != d0[31]) || (d1[32] != d1[31]) || (d2[32] != d2[31]) ||
           (d3[32] != d3[31]) || (d4[32] != d4[31]) || (d5[32] != d5[31]);
  end

  // Cross product operand schedule
  always_comb begin
    case (mc)
      3'd0:    begin op1 = e1; op2 = e5; end
      3'd1:    begin op1 = e2; op2 = e4; end
      3'd2:    begin op1 = e2; op2 = e3; end
      3'd3:    begin op1 = e0; op2 = e5; end
      3'd4:    begin op1 = e0; op2 = e4; end
      default: begin op1 = e1; op2 = e3; end
    endcase
    kk = mc - 3'd1;
  end

  // Normalizer
  assign norm_go = (state == S_RSTART) || (state == S_FSTART);
  always_comb begin
    if (cur.op == REQ_READ) begin
      nvx = {{32{acc_rd[95]}}, acc_rd[95:64]};
      nvy = {{32{acc_rd[63]}}, acc_rd[63:32]};
      nvz = {{32{acc_rd[31]}}, acc_rd[31:0]};
    end else begin
      nvx = cr0;
      nvy = cr1;
      nvz = cr2;
    end
  end

  svng_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (norm_go),
    .vx    (nvx),
    .vy    (nvy),
    .vz    (nvz),
    .done  (norm_done),
    .nx    (nox),
    .ny    (noy),
    .nz    (noz)
  );

  assign take      = (state == S_IDLE) && in_valid;
  assign init_busy = init;
  assign slot_free = !out_valid || pop;
  assign empty     = !out_valid;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      init  <= 1'b1;
      sw    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_item.err) begin
              state <= S_DONE;
            end else begin
              case (in_item.op)
                REQ_WRITE: state <= S_WRITE;
                REQ_READ:  state <= S_RACC;
                REQ_TRI:   state <= S_PA;
                default: begin
                  sw    <= '0;
                  state <= S_CLEAR;
                end
              endcase
            end
          end
        end
        S_CLEAR: begin
          sw <= sw + 1'b1;
          if (sw == LAST) begin
            init  <= 1'b0;
            state <= init ? S_IDLE : S_DONE;
          end
        end
        S_WRITE:  state <= S_DONE;
        S_RACC:   state <= S_RSTART;
        S_RSTART: state <= S_NWAIT;
        S_PA:     state <= S_PB;
        S_PB:     state <= S_PC;
        S_PC:     state <= S_EDGE;
        S_EDGE:   state <= S_MUL;
        S_MUL: begin
          if (mc == 3'd6) state <= S_FSTART;
        end
        S_FSTART: state <= S_NWAIT;
        S_NWAIT: begin
          if (norm_done) state <= (cur.op == REQ_READ) ? S_DONE : S_ARD;
        end
        S_ARD: state <= S_AWR;
        S_AWR: state <= (j == 2'd2) ? S_DONE : S_ARD;
        S_DONE: begin
          if (slot_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        cur <= in_item;
        rnx <= '0;
        rny <= '0;
        rnz <= '0;
      end
      S_PB: pa <= pos_rd;
      S_PC: pb <= pos_rd;
      S_EDGE: begin
        e0  <= fit(d0, wide);
        e1  <= fit(d1, wide);
        e2  <= fit(d2, wide);
        e3  <= fit(d3, wide);
        e4  <= fit(d4, wide);
        e5  <= fit(d5, wide);
        cr0 <= '0;
        cr1 <= '0;
        cr2 <= '0;
        mc  <= 3'd0;
      end
      S_MUL: begin
        // product registered, folded into the cross term next cycle
        if (mc != 3'd6) prod <= op1 * op2;
        if (mc != 3'd0) begin
          case (kk)
            3'd0:    cr0 <= cr0 + prod;
            3'd1:    cr0 <= cr0 - prod;
            3'd2:    cr1 <= cr1 + prod;
            3'd3:    cr1 <= cr1 - prod;
            3'd4:    cr2 <= cr2 + prod;
            default: cr2 <= cr2 - prod;
          endcase
        end
        mc <= mc + 3'd1;
      end
      S_NWAIT: begin
        if (norm_done) begin
          j <= 2'd0;
          if (cur.op == REQ_READ) begin
            rnx <= nox;
            rny <= noy;
            rnz <= noz;
          end else begin
            fnx <= nox;
            fny <= noy;
            fnz <= noz;
          end
        end
      end
      S_AWR: j <= j + 2'd1;
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && slot_free) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && slot_free) begin
      normal_x <= rnx;
      normal_y <= rny;
      normal_z <= rnz;
      status   <= cur.err;
    end
  end

endmodule

// ===== rtl/smooth_vertex_normal_generator.sv =====
// Smooth vertex normal generator: one request in, one result out, in order.
// Throughput: one request at a time in the back-end sequencer, bound by the shared
// normalizer (shift, sqrt, divide); a stalled result register holds the next one.
// Reset is synchronous; then a clearing pass over the accumulator memory runs, full high.
module smooth_vertex_normal_generator import svng_pkg::*; #(
  parameter int MAX_VERTICES = 4096
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic [1:0]              req_type,
  input  logic [IDX_W-1:0]        vtx_index,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic signed [POS_W-1:0] pos_z,
  input  logic [IDX_W-1:0]        corner_a,
  input  logic [IDX_W-1:0]        corner_b,
  input  logic [IDX_W-1:0]        corner_c,
  output logic                    empty,
  input  logic                    pop,
  output logic signed [NRM_W-1:0] normal_x,
  output logic signed [NRM_W-1:0] normal_y,
  output logic signed [NRM_W-1:0] normal_z,
  output logic                    status,
  input  logic                    cfg_we,
  input  logic [COUNT_W-1:0]      cfg_wdata
);

  logic [COUNT_W-1:0] vertex_count;
  logic               q_valid;
  item_t              q_item;
  logic               take;
  logic               init_busy;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  svng_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .hold         (init_busy),
    .req_type     (req_type),
    .vtx_index    (vtx_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .vertex_count (vertex_count),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .take         (take)
  );

  svng_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .take      (take),
    .init_busy (init_busy),
    .pop       (pop),
    .empty     (empty),
    .normal_x  (normal_x),
    .normal_y  (normal_y),
    .normal_z  (normal_z),
    .status    (status)
  );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for smooth_vertex_normal_generator.
// Depends on svng_pkg (rtl/svng_pkg.sv) and the block's top module; a built-in
// predictor models positions, accumulators and unit scaling to check every result.
module tb;
  import svng_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV         = 4096;
  localparam int CYCLE_MAX  = 1500000;
  localparam int SETTLE_CYC = 200;

  typedef struct {
    logic [1:0]              op;
    logic [IDX_W-1:0]        vidx;
    logic signed [POS_W-1:0] px, py, pz;
    logic [IDX_W-1:0]        ca, cb, cc;
  } mesh_req_t;

  typedef struct {
    logic signed [NRM_W-1:0] nx, ny, nz;
    logic                    st;
  } mesh_rsp_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] x, y, z;
  } unit_vec_t;

  // DUT ports; the inputs are known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0, pop = 1'b0, cfg_we = 1'b0;
  logic full, empty, status;
  logic [1:0] req_type = REQ_WRITE;
  logic [IDX_W-1:0] vtx_index = '0, corner_a = '0, corner_b = '0, corner_c = '0;
  logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;
  logic [COUNT_W-1:0] cfg_wdata = '0;

  smooth_vertex_normal_generator uut (
    .clk, .rst, .push, .full, .req_type, .vtx_index, .pos_x, .pos_y, .pos_z,
    .corner_a, .corner_b, .corner_c, .empty, .pop, .normal_x, .normal_y, .normal_z,
    .status, .cfg_we, .cfg_wdata
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state
  int mdl_count;
  int mdl_px[NV], mdl_py[NV], mdl_pz[NV];
  int mdl_ax[NV], mdl_ay[NV], mdl_az[NV];

  mesh_req_t pending_reqs[$];
  mesh_rsp_t expected_rsps[$];
  int n_errors  = 0;
  int n_cycles  = 0;
  int n_queued  = 0;
  int n_sent    = 0;

  // Stimulus-side bookkeeping: which vertices hold a position
  int  gen_count;
  bit  gen_written[NV];
  int  usable_q[$];

  function automatic logic [63:0] isqrt64(logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  // Scale a vector to unit length in Q1.15, zero stays zero
  function automatic unit_vec_t unit_scale(longint vx, longint vy, longint vz);
    longint v[3];
    logic [63:0] m[3];
    logic [63:0] mx, len, q;
    bit neg[3];
    logic signed [NRM_W-1:0] o[3];
    v = '{vx, vy, vz};
    mx = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      m[i] = neg[i] ? 64'(-v[i]) : 64'(v[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return '0;
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    len = isqrt64(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << 15) + (len >> 1)) / len;
      if (neg[i]) o[i] = (q > 64'd32768) ? 16'sh8000 : 16'(64'd0 - q);
      else o[i] = (q > 64'd32767) ? 16'sh7fff : 16'(q);
    end
    return '{o[0], o[1], o[2]};
  endfunction

  function automatic int sat_sum(int a, int b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) return 32'h7fffffff;
    if (s < -64'sd2147483648) return 32'h80000000;
    return int'(s);
  endfunction

  function automatic bit idx_ok(int i);
    return i < mdl_count && i < NV;
  endfunction

  // Work out the result of one transaction and update the model state
  function automatic mesh_rsp_t predict_normal(mesh_req_t r);
    mesh_rsp_t o;
    longint e[6];
    longint cx, cy, cz;
    unit_vec_t fn;
    int a, b, c;
    bit wide;
    o = '{0, 0, 0, 1'b0};
    a = r.ca; b = r.cb; c = r.cc;
    case (r.op)
      REQ_WRITE: begin
        if (idx_ok(r.vidx)) begin
          mdl_px[r.vidx] = r.px;
          mdl_py[r.vidx] = r.py;
          mdl_pz[r.vidx] = r.pz;
        end else o.st = 1'b1;
      end
      REQ_TRI: begin
        if (idx_ok(a) && idx_ok(b) && idx_ok(c)) begin
          e[0] = longint'(mdl_px[b]) - mdl_px[a];
          e[1] = longint'(mdl_py[b]) - mdl_py[a];
          e[2] = longint'(mdl_pz[b]) - mdl_pz[a];
          e[3] = longint'(mdl_px[c]) - mdl_px[a];
          e[4] = longint'(mdl_py[c]) - mdl_py[a];
          e[5] = longint'(mdl_pz[c]) - mdl_pz[a];
          wide = 0;
          for (int i = 0; i < 6; i++)
            if (e[i] > 64'sd2147483647 || e[i] < -64'sd2147483648) wide = 1;
          if (wide) for (int i = 0; i < 6; i++) e[i] = e[i] / 2;
          cx = e[1] * e[5] - e[2] * e[4];
          cy = e[2] * e[3] - e[0] * e[5];
          cz = e[0] * e[4] - e[1] * e[3];
          fn = unit_scale(cx, cy, cz);
          foreach (e[k]) if (k < 3) begin
            int v;
            v = (k == 0) ? a : (k == 1) ? b : c;
            mdl_ax[v] = sat_sum(mdl_ax[v], fn.x);
            mdl_ay[v] = sat_sum(mdl_ay[v], fn.y);
            mdl_az[v] = sat_sum(mdl_az[v], fn.z);
          end
        end else o.st = 1'b1;
      end
      REQ_READ: begin
        if (idx_ok(r.vidx)) begin
          fn = unit_scale(mdl_ax[r.vidx], mdl_ay[r.vidx], mdl_az[r.vidx]);
          o.nx = fn.x; o.ny = fn.y; o.nz = fn.z;
        end else o.st = 1'b1;
      end
      default: begin
        for (int i = 0; i < NV; i++) begin
          mdl_ax[i] = 0; mdl_ay[i] = 0; mdl_az[i] = 0;
        end
      end
    endcase
    return o;
  endfunction

  // Mostly short gaps, a few long, with idle-free stretches
  int burst_left = 0;
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) burst_left = $urandom_range(10, 40);
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Driver: one transaction per accepted push
  int send_gap = 0;
  always @(posedge clk) begin
    mesh_req_t cur;
    if (!rst) begin
      if (push && !full) begin
        cur.op = req_type; cur.vidx = vtx_index;
        cur.px = pos_x; cur.py = pos_y; cur.pz = pos_z;
        cur.ca = corner_a; cur.cb = corner_b; cur.cc = corner_c;
        expected_rsps.insert(expected_rsps.size(), predict_normal(cur));
        n_sent++;
      end
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          cur = pending_reqs.pop_front();
          req_type <= cur.op; vtx_index <= cur.vidx;
          pos_x <= cur.px; pos_y <= cur.py; pos_z <= cur.pz;
          corner_a <= cur.ca; corner_b <= cur.cb; corner_c <= cur.cc;
          push <= 1'b1;
          send_gap = pick_gap();
        end else push <= 1'b0;
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation
  int pop_stall = 0;
  always @(posedge clk) begin
    mesh_rsp_t exp_rsp;
    if (!rst) begin
      if (pop && !empty) begin
        if (expected_rsps.size() == 0) begin
          $error("result with no transaction outstanding");
          n_errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          if (normal_x !== exp_rsp.nx) begin
            $error("normal_x expected %0d actual %0d", exp_rsp.nx, normal_x);
            n_errors++;
          end
          if (normal_y !== exp_rsp.ny) begin
            $error("normal_y expected %0d actual %0d", exp_rsp.ny, normal_y);
            n_errors++;
          end
          if (normal_z !== exp_rsp.nz) begin
            $error("normal_z expected %0d actual %0d", exp_rsp.nz, normal_z);
            n_errors++;
          end
          if (status !== exp_rsp.st) begin
            $error("status expected %0d actual %0d", exp_rsp.st, status);
            n_errors++;
          end
        end
        pop_stall = pick_gap();
      end else if (pop_stall > 0) pop_stall--;
      pop <= (pop_stall == 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_MAX) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic queue_req(logic [1:0] op, int vi, int px, int py, int pz,
                           int a, int b, int c);
    mesh_req_t r;
    r = '{op, vi[IDX_W-1:0], px, py, pz, a[IDX_W-1:0], b[IDX_W-1:0], c[IDX_W-1:0]};
    if (op == REQ_WRITE && vi < gen_count && vi < NV && !gen_written[vi]) begin
      gen_written[vi] = 1;
      usable_q.insert(usable_q.size(), vi);
    end
    pending_reqs.insert(pending_reqs.size(), r);
    n_queued++;
  endtask

  task automatic set_vertex_count(int cnt);
    while (n_sent != n_queued || expected_rsps.size() != 0) @(negedge clk);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cnt[COUNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    mdl_count = cnt;
    gen_count = cnt;
    usable_q.delete();
    for (int i = 0; i < NV && i < cnt; i++)
      if (gen_written[i]) usable_q.insert(usable_q.size(), i);
    @(negedge clk);
  endtask

  function automatic int rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $signed($urandom_range(0, 2 * 655360)) - 655360;
    if (r < 9) return $urandom;
    return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
  endfunction

  // A corner either holds a position or is out of range
  function automatic int pick_corner(bit want_bad);
    if (want_bad && gen_count < NV) return $urandom_range(gen_count, NV - 1);
    return usable_q[$urandom_range(0, usable_q.size() - 1)];
  endfunction

  function automatic int pick_index();
    if (gen_count > 0 && gen_count <= NV && $urandom_range(0, 9) < 8)
      return $urandom_range(0, gen_count - 1);
    if (gen_count > 0 && gen_count < NV && $urandom_range(0, 1) == 0)
      return $urandom_range(0, gen_count - 1);
    return $urandom_range(0, NV - 1);
  endfunction

  task automatic queue_random(int n);
    int r;
    bit bad;
    repeat (n) begin
      r = $urandom_range(0, 99);
      bad = ($urandom_range(0, 9) == 0) && gen_count < NV;
      if (r == 0) queue_req(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom);
      else if (r < 30 || (r < 70 && usable_q.size() == 0 && !bad))
        queue_req(REQ_WRITE, pick_index(), rand_coord(), rand_coord(), rand_coord(),
                  $urandom, $urandom, $urandom);
      else if (r < 70)
        queue_req(REQ_TRI, $urandom, $urandom, $urandom, $urandom,
                  pick_corner(bad && $urandom_range(0, 2) == 0), pick_corner(bad),
                  pick_corner(bad && $urandom_range(0, 2) == 0));
      else
        queue_req(REQ_READ, pick_index(), $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    int counts[7] = '{0, 8191, 3, 64, 4096, 1000, 16};
    int reps[7]   = '{40, 150, 150, 160, 170, 170, 160};
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: basic normals, wide edges, degenerate and repeated corners, clear
    set_vertex_count(4096);
    queue_req(REQ_WRITE, 0, 0, 0, 0, 0, 0, 0);
    queue_req(REQ_WRITE, 1, 65536, 0, 0, 0, 0, 0);
    queue_req(REQ_WRITE, 2, 0, 65536, 0, 0, 0, 0);
    queue_req(REQ_TRI, 0, 0, 0, 0, 0, 1, 2);
    queue_req(REQ_READ, 1, 0, 0, 0, 0, 0, 0);
    queue_req(REQ_TRI, 0, 0, 0, 0, 0, 2, 1);
    queue_req(REQ_READ, 1, 0, 0, 0, 0, 0, 0);
    queue_req(REQ_WRITE, 4095, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0);
    queue_req(REQ_WRITE, 3, 32'h80000000, 32'h7fffffff, 32'h80000000, 0, 0, 0);
    queue_req(REQ_WRITE, 4, 32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0, 0);
    queue_req(REQ_TRI, 0, 0, 0, 0, 3, 4095, 4);
    queue_req(REQ_TRI, 0, 0, 0, 0, 0, 0, 1);
    queue_req(REQ_TRI, 0, 0, 0, 0, 4, 4, 4095);
    queue_req(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
    queue_req(REQ_READ, 3, 0, 0, 0, 0, 0, 0);
    queue_req(REQ_READ, 4095, 0, 0, 0, 0, 0, 0);
    queue_req(REQ_READ, 100, 0, 0, 0, 0, 0, 0);
    queue_req(REQ_CLEAR, 4095, -1, -1, -1, 4095, 4095, 4095);
    queue_req(REQ_READ, 4095, 0, 0, 0, 0, 0, 0);
    queue_req(REQ_TRI, 0, 0, 0, 0, 0, 1, 2);
    queue_req(REQ_READ, 2, 0, 0, 0, 0, 0, 0);

    for (int p = 0; p < 7; p++) begin
      set_vertex_count(counts[p]);
      queue_random(reps[p]);
    end

    while (n_sent != n_queued || expected_rsps.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (n_errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/svng_pkg.sv
rtl/svng_norm.sv
rtl/svng_front.sv
rtl/svng_back.sv
rtl/smooth_vertex_normal_generator.sv
test/tb.sv
